// ===== sv/plma_pkg.sv =====
package plma_pkg;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_MAP   = 2'd2;

    localparam int ADDR_W      = 32;
    localparam int DATA_W      = 64;
    localparam int BYTE_W      = 8;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_LSB_W  = 3;
    localparam int WORD_ADDR_W = ADDR_W - WORD_LSB_W;
    localparam int MAP_PAGE_W  = 8;
    localparam int MAP_FRAME_W = 6;
    localparam int MAP_FRAMES  = 1 << MAP_FRAME_W;

    // Control of one store bank for a single access.
    typedef struct packed {
        logic                  en;
        logic                  we;
        logic [WORD_BYTES-1:0] be;
    } t_bank_ctl;

endpackage

// ===== sv/paged_linear_memory_access.sv =====
// Paged linear memory with a single-level page table. A map word writes one page table
// entry (valid bit and frame number); read and write words move 1, 2, 4 or 8 bytes at a
// 32-bit linear offset, little-endian, with reads zero-extended. Each byte is translated
// through the page of its own address, so an access that crosses a page boundary lands in
// two frames; an unmapped page on any touched byte raises fault, returns zero and blocks
// the whole store. An item goes first through the page table read and then the frame
// store access, after which the result sits in an output register while the next
// word is already taken in. The frame store is two 64-bit banks (even and odd words) so
// that the two words an unaligned access can touch are served in the same cycle. After
// reset the block sweeps the page table clear, one entry a cycle, over all PAGE_COUNT
// entries, and takes no input word until the sweep is done. PAGE_COUNT and PAGE_SIZE
// must be powers of two; FRAME_COUNT may be any value in its range.
module paged_linear_memory_access #(
    parameter int PAGE_COUNT  = 256,
    parameter int PAGE_SIZE   = 1024,
    parameter int FRAME_COUNT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_req_type,
    input  logic [plma_pkg::ADDR_W-1:0]         i_address,
    input  logic [1:0]                          i_access_size,
    input  logic [plma_pkg::DATA_W-1:0]         i_write_data,
    input  logic [plma_pkg::MAP_PAGE_W-1:0]     i_map_page,
    input  logic [plma_pkg::MAP_FRAME_W-1:0]    i_map_frame,
    input  logic                                i_map_valid,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [plma_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_fault,
    output logic                                o_crossed_page
);
    import plma_pkg::*;

    // Derived geometry.
    localparam int PGB        = $clog2(PAGE_SIZE);
    localparam int PGB1       = PGB + 1;
    localparam int PB         = $clog2(PAGE_COUNT);
    localparam int FW         = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int WOFF_W     = PGB - WORD_LSB_W;
    localparam int PHW        = FW + WOFF_W;
    localparam int BANK_AW    = PHW - 1;
    localparam int BANK_DEPTH = FRAME_COUNT * (PAGE_SIZE / (2 * WORD_BYTES));
    localparam int PTE_W      = FW + 1;

    // State codes.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_XLATE = 2'd2;
    localparam logic [1:0] ST_DATA  = 2'd3;

    // The frame number of a map word is reduced modulo FRAME_COUNT through a small table.
    function automatic logic [MAP_FRAMES*FW-1:0] build_frame_lut();
        logic [MAP_FRAMES*FW-1:0] v;
        v = '0;
        for (int k = 0; k < MAP_FRAMES; k++) begin
            v[k*FW +: FW] = FW'(k % FRAME_COUNT);
        end
        return v;
    endfunction

    localparam logic [MAP_FRAMES*FW-1:0] FRAME_LUT = build_frame_lut();

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [PB-1:0]       r_clr_idx;

    // Request captured at acceptance.
    logic [1:0]          r_req;
    logic [ADDR_W-1:0]   r_addr;
    logic [1:0]          r_size;
    logic [DATA_W-1:0]   r_wdata;

    // Outcome of translation, carried into the data cycle.
    logic                r_res_fault;
    logic                r_res_crossed;
    logic                r_res_load;

    // Output register.
    logic                r_o_valid;
    logic [DATA_W-1:0]   r_o_read_data;
    logic                r_o_fault;
    logic                r_o_crossed;

    logic                w_accept;
    logic                w_finish;

    // Page table port signals.
    logic                    w_pt_we;
    logic [PB-1:0]           w_pt_waddr;
    logic [PTE_W-1:0]        w_pt_wdata;
    logic [WORD_ADDR_W-1:0]  w_in_word_b;
    logic [PTE_W-1:0]        w_pte_a;
    logic [PTE_W-1:0]        w_pte_b;

    // Translation cycle signals.
    logic [3:0]              w_nbytes;
    logic [WORD_BYTES-1:0]   w_byte_mask;
    logic                    w_spill;
    logic                    w_crossed;
    logic                    w_is_rw;
    logic                    w_fault;
    logic                    w_mem_go;
    logic [WORD_ADDR_W-1:0]  w_word_b;
    logic [PHW-1:0]          w_phys_a;
    logic [PHW-1:0]          w_phys_b;
    logic [2*WORD_BYTES-1:0] w_be_wide;
    logic [2*DATA_W-1:0]     w_wdata_wide;
    t_bank_ctl               w_ctl_a;
    t_bank_ctl               w_ctl_b;
    t_bank_ctl               w_ctl0;
    t_bank_ctl               w_ctl1;
    logic [BANK_AW-1:0]      w_addr0;
    logic [BANK_AW-1:0]      w_addr1;
    logic [DATA_W-1:0]       w_wd0;
    logic [DATA_W-1:0]       w_wd1;
    logic [DATA_W-1:0]       w_rd0;
    logic [DATA_W-1:0]       w_rd1;

    // Data cycle signals.
    logic [DATA_W-1:0]       w_rd_a;
    logic [DATA_W-1:0]       w_rd_b;
    logic [2*DATA_W-1:0]     w_rd_shift;
    logic [DATA_W-1:0]       w_rd_bitmask;
    logic [DATA_W-1:0]       w_load_data;

    // A new word is taken while idle, or in the data cycle as the current result retires.
    assign w_finish = (r_state == ST_DATA) && (!r_o_valid || i_ready);
    assign o_ready  = (r_state == ST_IDLE) || w_finish;
    assign w_accept = i_valid && o_ready;

    // ---------------------------------------------------------------------------------
    // Page table: cleared by the sweep after reset, written by map words on acceptance,
    // read for both candidate pages of every accepted word.
    // ---------------------------------------------------------------------------------
    assign w_in_word_b = i_address[ADDR_W-1:WORD_LSB_W] + WORD_ADDR_W'(1);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_pt_we    = 1'b1;
            w_pt_waddr = r_clr_idx;
            w_pt_wdata = '0;
        end else begin
            w_pt_we    = w_accept && (i_req_type == REQ_MAP);
            w_pt_waddr = PB'(i_map_page);
            w_pt_wdata = {i_map_valid, FRAME_LUT[int'(i_map_frame)*FW +: FW]};
        end
    end

    plma_ptab #(
        .ENTRIES (PAGE_COUNT),
        .AW      (PB),
        .DW      (PTE_W)
    ) u_ptab (
        .i_clk     (i_clk),
        .i_we      (w_pt_we),
        .i_waddr   (w_pt_waddr),
        .i_wdata   (w_pt_wdata),
        .i_re      (w_accept),
        .i_raddr_a (i_address[PGB +: PB]),
        .i_raddr_b (w_in_word_b[WOFF_W +: PB]),
        .o_rdata_a (w_pte_a),
        .o_rdata_b (w_pte_b)
    );

    // ---------------------------------------------------------------------------------
    // Translation. An access of up to eight bytes touches linear word A (holding the first
    // byte) and possibly word B, the next one. A page holds whole words, so each word has
    // a single page and a single frame.
    // ---------------------------------------------------------------------------------
    always_comb begin
        case (r_size)
            2'd0:    w_byte_mask = 8'h01;
            2'd1:    w_byte_mask = 8'h03;
            2'd2:    w_byte_mask = 8'h0F;
            default: w_byte_mask = 8'hFF;
        endcase
    end

    assign w_nbytes  = 4'd1 << r_size;
    assign w_spill   = ({1'b0, r_addr[WORD_LSB_W-1:0]} + w_nbytes) > 4'(WORD_BYTES);
    assign w_crossed = ({1'b0, r_addr[PGB-1:0]} + PGB1'(w_nbytes)) > PGB1'(PAGE_SIZE);
    assign w_is_rw   = r_req inside {REQ_READ, REQ_WRITE};
    assign w_fault   = w_is_rw && (!w_pte_a[FW] || (w_spill && !w_pte_b[FW]));
    assign w_mem_go  = (r_state == ST_XLATE) && w_is_rw && !w_fault;

    assign w_word_b = r_addr[ADDR_W-1:WORD_LSB_W] + WORD_ADDR_W'(1);
    assign w_phys_a = {w_pte_a[FW-1:0], r_addr[PGB-1:WORD_LSB_W]};
    assign w_phys_b = {w_pte_b[FW-1:0], w_word_b[WOFF_W-1:0]};

    assign w_be_wide    = {{WORD_BYTES{1'b0}}, w_byte_mask} << r_addr[WORD_LSB_W-1:0];
    assign w_wdata_wide = {{DATA_W{1'b0}}, r_wdata} << {r_addr[WORD_LSB_W-1:0], 3'b000};

    always_comb begin
        w_ctl_a.en = w_mem_go;
        w_ctl_a.we = (r_req == REQ_WRITE);
        w_ctl_a.be = w_be_wide[WORD_BYTES-1:0];
        w_ctl_b.en = w_mem_go;
        w_ctl_b.we = (r_req == REQ_WRITE);
        w_ctl_b.be = w_be_wide[2*WORD_BYTES-1:WORD_BYTES];
    end

    // Word A sits in the even bank when its linear word index is even.
    always_comb begin
        if (r_addr[WORD_LSB_W]) begin
            w_ctl0  = w_ctl_b;
            w_addr0 = w_phys_b[PHW-1:1];
            w_wd0   = w_wdata_wide[2*DATA_W-1:DATA_W];
            w_ctl1  = w_ctl_a;
            w_addr1 = w_phys_a[PHW-1:1];
            w_wd1   = w_wdata_wide[DATA_W-1:0];
        end else begin
            w_ctl0  = w_ctl_a;
            w_addr0 = w_phys_a[PHW-1:1];
            w_wd0   = w_wdata_wide[DATA_W-1:0];
            w_ctl1  = w_ctl_b;
            w_addr1 = w_phys_b[PHW-1:1];
            w_wd1   = w_wdata_wide[2*DATA_W-1:DATA_W];
        end
    end

    plma_bank #(
        .AW    (BANK_AW),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl0),
        .i_addr  (w_addr0),
        .i_wdata (w_wd0),
        .o_rdata (w_rd0)
    );

    plma_bank #(
        .AW    (BANK_AW),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl1),
        .i_addr  (w_addr1),
        .i_wdata (w_wd1),
        .o_rdata (w_rd1)
    );

    // ---------------------------------------------------------------------------------
    // Data cycle: realign the two words, keep only the requested bytes.
    // ---------------------------------------------------------------------------------
    assign w_rd_a     = r_addr[WORD_LSB_W] ? w_rd1 : w_rd0;
    assign w_rd_b     = r_addr[WORD_LSB_W] ? w_rd0 : w_rd1;
    assign w_rd_shift = {w_rd_b, w_rd_a} >> {r_addr[WORD_LSB_W-1:0], 3'b000};

    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            w_rd_bitmask[k*BYTE_W +: BYTE_W] = {BYTE_W{w_byte_mask[k]}};
        end
    end

    assign w_load_data = r_res_load ? (w_rd_shift[DATA_W-1:0] & w_rd_bitmask) : '0;

    // ---------------------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == PB'(PAGE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_XLATE;
                end
            end
            ST_XLATE: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                if (w_finish) begin
                    n_state = w_accept ? ST_XLATE : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + PB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_addr  <= i_address;
            r_size  <= i_access_size;
            r_wdata <= i_write_data;
        end
        if (r_state == ST_XLATE) begin
            r_res_fault   <= w_fault;
            r_res_crossed <= w_is_rw && w_crossed;
            r_res_load    <= (r_req == REQ_READ) && !w_fault;
        end
    end

    // Output register: loaded as an item retires, emptied when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_finish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_o_read_data <= w_load_data;
            r_o_fault     <= r_res_fault;
            r_o_crossed   <= r_res_crossed;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_read_data    = r_o_read_data;
    assign o_fault        = r_o_fault;
    assign o_crossed_page = r_o_crossed;

    // ---------------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------------
    a_accept_to_xlate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_XLATE))
        else $error("accepted word did not enter translation");

    a_xlate_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XLATE) |=> (r_state == ST_DATA))
        else $error("translation cycle not followed by data cycle");

    a_fault_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_read_data == '0))
        else $error("faulting word returned data");

    a_no_store_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_XLATE) && (w_ctl0.en || w_ctl1.en)) |=> !r_res_fault)
        else $error("frame store accessed by a faulting word");

endmodule

// ===== sv/plma_bank.sv =====
module plma_bank #(
    parameter int AW    = 10,
    parameter int DEPTH = 1024
) (
    input  logic                    i_clk,
    input  plma_pkg::t_bank_ctl     i_ctl,
    input  logic [AW-1:0]           i_addr,
    input  logic [plma_pkg::DATA_W-1:0] i_wdata,
    output logic [plma_pkg::DATA_W-1:0] o_rdata
);
    import plma_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Byte-lane writes, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                for (int k = 0; k < WORD_BYTES; k++) begin
                    if (i_ctl.be[k]) begin
                        mem[i_addr][k*BYTE_W +: BYTE_W] <= i_wdata[k*BYTE_W +: BYTE_W];
                    end
                end
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/plma_ptab.sv =====
module plma_ptab #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8,
    parameter int DW      = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [ENTRIES];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports: the page of the first word and the page of the next word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
